[rtl/pct_pkg.sv]
// Shared types and constants for the pitch candidate table.
package pct_pkg;

  localparam int FREQ_W = 16;
  localparam int STR_W  = 16;
  localparam int MC_W   = 5;
  localparam int MS_W   = 15;
  localparam int CNT_OUT_W = 5;

  // Divider: the magnitude of strength * max_strength stays below 2**30
  localparam int MAG_W     = 30;
  localparam int DIV_STEPS = 30;
  localparam int STEP_W    = 5;

  localparam logic signed [STR_W-1:0] STR_MIN = {1'b1, {(STR_W-1){1'b0}}};
  localparam logic signed [STR_W-1:0] STR_MAX = {1'b0, {(STR_W-1){1'b1}}};

  localparam logic [1:0] ACT_CLEAR = 2'd0;
  localparam logic [1:0] ACT_ADD   = 2'd1;
  localparam logic [1:0] ACT_NORM  = 2'd2;

  localparam logic [1:0] REG_MAX_CAND  = 2'd0;
  localparam logic [1:0] REG_MAX_STR   = 2'd1;
  localparam logic [1:0] REG_UNV_CRIT  = 2'd2;

  typedef struct packed {
    logic [1:0]              action;
    logic [FREQ_W-1:0]       cand_freq_in;
    logic signed [STR_W-1:0] cand_strength_in;
  } cand_t;

  typedef struct packed {
    logic [FREQ_W-1:0]       best_frequency;
    logic signed [STR_W-1:0] best_strength;
    logic [CNT_OUT_W-1:0]    entry_count;
    logic                    was_stored;
  } result_t;

  typedef struct packed {
    logic [FREQ_W-1:0]       freq;
    logic signed [STR_W-1:0] strength;
  } slot_t;

  typedef struct packed {
    logic                    start;
    logic signed [STR_W-1:0] strength;
    logic [MS_W-1:0]         scale;
    logic signed [STR_W-1:0] divisor;
  } div_req_t;

  typedef struct packed {
    logic                    done;
    logic signed [STR_W-1:0] quotient;
  } div_rsp_t;

endpackage

[rtl/pct_ram.sv]
// Generic single-port-write, single-port-read RAM with registered read data.
module pct_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

[rtl/pct_div.sv]
// Multiply then restoring divide, one quotient bit a cycle, saturated to Q1.15.
module pct_div (
  input  logic                clk,
  input  logic                rst,
  input  pct_pkg::div_req_t   req,
  output pct_pkg::div_rsp_t   rsp
);

  localparam logic [2:0] D_IDLE = 3'd0;
  localparam logic [2:0] D_MUL  = 3'd1;
  localparam logic [2:0] D_PREP = 3'd2;
  localparam logic [2:0] D_ITER = 3'd3;
  localparam logic [2:0] D_DONE = 3'd4;

  logic [2:0]                         state;
  logic signed [pct_pkg::STR_W-1:0]   a_r;
  logic [pct_pkg::MS_W-1:0]           b_r;
  logic signed [pct_pkg::STR_W-1:0]   d_r;
  logic signed [31:0]                 prod;
  logic                               neg;
  logic [15:0]                        dvs;
  logic [15:0]                        rem;
  logic [pct_pkg::MAG_W-1:0]          qd;
  logic [pct_pkg::STEP_W-1:0]         step;

  logic [31:0]                        pmag;
  logic [16:0]                        dmag;
  logic [16:0]                        trial;
  logic                               qbit;
  logic [16:0]                        trial_sub;
  logic signed [pct_pkg::STR_W-1:0]   sat_q;

  assign pmag  = prod[31] ? 32'(-prod) : 32'(prod);
  assign dmag  = d_r[pct_pkg::STR_W-1] ? 17'(-{d_r[pct_pkg::STR_W-1], d_r})
                                        : 17'({d_r[pct_pkg::STR_W-1], d_r});
  assign trial = {rem, qd[pct_pkg::MAG_W-1]};
  assign qbit  = (trial >= {1'b0, dvs});
  assign trial_sub = trial - {1'b0, dvs};

  always_comb begin
    if (neg) begin
      if (qd > pct_pkg::MAG_W'(32768)) begin
        sat_q = pct_pkg::STR_MIN;
      end else begin
        sat_q = pct_pkg::STR_W'(-qd[15:0]);
      end
    end else begin
      if (qd > pct_pkg::MAG_W'(32767)) begin
        sat_q = pct_pkg::STR_MAX;
      end else begin
        sat_q = qd[15:0];
      end
    end
  end

  assign rsp.done     = (state == D_DONE);
  assign rsp.quotient = sat_q;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= D_IDLE;
    end else begin
      unique case (state)
        D_IDLE: begin
          if (req.start) begin
            a_r   <= req.strength;
            b_r   <= req.scale;
            d_r   <= req.divisor;
            state <= D_MUL;
          end
        end
        D_MUL: begin
          prod  <= a_r * $signed({1'b0, b_r});
          state <= D_PREP;
        end
        D_PREP: begin
          neg   <= prod[31] ^ d_r[pct_pkg::STR_W-1];
          qd    <= pmag[pct_pkg::MAG_W-1:0];
          dvs   <= dmag[15:0];
          rem   <= '0;
          step  <= '0;
          state <= D_ITER;
        end
        D_ITER: begin
          rem  <= qbit ? trial_sub[15:0] : trial[15:0];
          qd   <= {qd[pct_pkg::MAG_W-2:0], qbit};
          step <= step + pct_pkg::STEP_W'(1);
          if (step == pct_pkg::STEP_W'(pct_pkg::DIV_STEPS - 1)) begin
            state <= D_DONE;
          end
        end
        D_DONE: begin
          state <= D_IDLE;
        end
        default: begin
          state <= D_IDLE;
        end
      endcase
    end
  end

endmodule

[rtl/pitch_candidate_table.sv]
// Pitch candidate table: clear, add and normalize under one sequencer.
//
// Input channel cand (cand_valid / cand_stall) carries one action a beat:
// clear, add a candidate, or normalize and reorder. Every beat yields one
// beat on the result channel (result_valid / result_stall) with the best
// voiced pick, the entry count and whether an add was stored.
// Configuration: cfg_write, cfg_index and cfg_data write max_candidates,
// max_strength and unvoiced_criterion; write only while the block is idle.
// One item is worked on at a time; cand_stall is high from acceptance until
// the result is loaded into the output register. An add runs one slot scan,
// or two when the table is full; a normalize finds the strongest slot,
// rescales each held slot by it in turn, may swap a candidate into slot
// one and scans again, skipping the divides when the strongest is zero.
// The slot RAM's single read port sets the scan cost, and the single
// multiply-divide unit, one quotient bit a cycle, sets the cost per slot.
// A finished result waits in the output register while result_stall is
// high; the next item may be accepted meanwhile and completes once the
// register frees. Reset empties the table and restores the register
// defaults; slot contents are not cleared.
module pitch_candidate_table #(
  parameter int TABLE_DEPTH = 16
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          cand_valid,
  output logic                          cand_stall,
  input  pct_pkg::cand_t                cand,
  output logic                          result_valid,
  input  logic                          result_stall,
  output pct_pkg::result_t              result,
  input  logic                          cfg_write,
  input  logic [1:0]                    cfg_index,
  input  logic [pct_pkg::MS_W-1:0]      cfg_data
);

  localparam int IDX_W  = $clog2(TABLE_DEPTH);
  localparam int CNT_W  = $clog2(TABLE_DEPTH + 1);
  localparam int WIDE_W = (CNT_W > pct_pkg::MC_W) ? CNT_W : pct_pkg::MC_W;
  localparam int SLOT_W = pct_pkg::FREQ_W + pct_pkg::STR_W;

  localparam logic [3:0] ST_IDLE   = 4'd0;
  localparam logic [3:0] ST_ADD    = 4'd1;
  localparam logic [3:0] ST_SINIT  = 4'd2;
  localparam logic [3:0] ST_SCAN   = 4'd3;
  localparam logic [3:0] ST_SDONE  = 4'd4;
  localparam logic [3:0] ST_NRD    = 4'd5;
  localparam logic [3:0] ST_NWAIT  = 4'd6;
  localparam logic [3:0] ST_NDIV   = 4'd7;
  localparam logic [3:0] ST_PICK   = 4'd8;
  localparam logic [3:0] ST_SRD0   = 4'd9;
  localparam logic [3:0] ST_SRDP   = 4'd10;
  localparam logic [3:0] ST_SWA    = 4'd11;
  localparam logic [3:0] ST_SWB    = 4'd12;
  localparam logic [3:0] ST_REPORT = 4'd13;

  localparam logic [1:0] SC_WEAK   = 2'd0;
  localparam logic [1:0] SC_STRONG = 2'd1;
  localparam logic [1:0] SC_BEST   = 2'd2;

  // configuration
  logic [pct_pkg::MC_W-1:0]           max_candidates;
  logic [pct_pkg::MS_W-1:0]           max_strength;
  logic [pct_pkg::MS_W-1:0]           unvoiced_criterion;

  logic [3:0]                         state;
  logic [1:0]                         act_r;
  logic [pct_pkg::FREQ_W-1:0]         f_r;
  logic signed [pct_pkg::STR_W-1:0]   s_r;
  logic [CNT_W-1:0]                   count;
  logic [CNT_W-1:0]                   idx;
  logic [WIDE_W-1:0]                  scan_end;
  logic                               pend;
  logic [IDX_W-1:0]                   pend_idx;
  logic [1:0]                         scan_kind;
  logic signed [pct_pkg::STR_W-1:0]   acc;
  logic [IDX_W-1:0]                   pos;
  logic                               found;
  logic [IDX_W-1:0]                   upos;
  logic                               ufound;
  logic [pct_pkg::FREQ_W-1:0]         bfreq;
  logic                               stored;
  logic [pct_pkg::FREQ_W-1:0]         keep_f;
  logic [IDX_W-1:0]                   swap_pos;
  pct_pkg::slot_t                     e0;
  logic                               out_valid;
  pct_pkg::result_t                   out_data;

  // RAM port
  logic                               ram_we;
  logic [IDX_W-1:0]                   ram_waddr;
  pct_pkg::slot_t                     ram_wslot;
  logic [IDX_W-1:0]                   ram_raddr;
  logic [SLOT_W-1:0]                  ram_rdata;
  pct_pkg::slot_t                     rd;

  pct_pkg::div_req_t                  div_req;
  pct_pkg::div_rsp_t                  div_rsp;

  logic [WIDE_W-1:0]                  lim;
  logic [WIDE_W-1:0]                  mc_ext;
  logic [WIDE_W-1:0]                  cnt_ext;
  logic [WIDE_W-1:0]                  idx_ext;
  logic                               scan_more;
  logic                               weak_hit;
  logic                               strong_hit;
  logic                               best_hit;
  logic                               repl_ok;
  logic [IDX_W-1:0]                   pick_pos;
  logic [CNT_W-1:0]                   idx_inc;

  assign rd        = pct_pkg::slot_t'(ram_rdata);
  assign mc_ext    = WIDE_W'(max_candidates);
  assign lim       = (mc_ext > WIDE_W'(TABLE_DEPTH)) ? WIDE_W'(TABLE_DEPTH) : mc_ext;
  assign cnt_ext   = WIDE_W'(count);
  assign idx_ext   = WIDE_W'(idx);
  assign scan_more = (idx_ext < scan_end);
  assign idx_inc   = idx + CNT_W'(1);

  assign weak_hit   = (rd.freq != '0) && (!found || (rd.strength < acc));
  assign strong_hit = !found || (rd.strength > acc);
  assign best_hit   = (rd.freq != '0) && (rd.strength > acc);
  // ties replace; a weaker newcomer is dropped
  assign repl_ok    = found && !(s_r < acc);
  assign pick_pos   = ((max_strength < unvoiced_criterion) && ufound) ? upos : pos;

  assign cand_stall   = (state != ST_IDLE);
  assign result_valid = out_valid;
  assign result       = out_data;

  assign div_req.start    = (state == ST_NWAIT);
  assign div_req.strength = rd.strength;
  assign div_req.scale    = max_strength;
  assign div_req.divisor  = acc;

  always_comb begin
    ram_we    = 1'b0;
    ram_waddr = '0;
    ram_wslot = '{freq: f_r, strength: s_r};
    ram_raddr = '0;
    unique case (state)
      ST_ADD: begin
        ram_we    = (cnt_ext < lim);
        ram_waddr = count[IDX_W-1:0];
      end
      ST_SCAN: begin
        ram_raddr = idx[IDX_W-1:0];
      end
      ST_SDONE: begin
        ram_we    = (scan_kind == SC_WEAK) && repl_ok;
        ram_waddr = pos;
      end
      ST_NRD: begin
        ram_raddr = idx[IDX_W-1:0];
      end
      ST_NDIV: begin
        ram_we    = div_rsp.done;
        ram_waddr = idx[IDX_W-1:0];
        ram_wslot = '{freq: keep_f, strength: div_rsp.quotient};
      end
      ST_SRDP: begin
        ram_raddr = swap_pos;
      end
      ST_SWA: begin
        ram_we    = 1'b1;
        ram_waddr = '0;
        ram_wslot = rd;
      end
      ST_SWB: begin
        ram_we    = 1'b1;
        ram_waddr = swap_pos;
        ram_wslot = e0;
      end
      default: begin
        ram_we = 1'b0;
      end
    endcase
  end

  pct_ram #(
    .WIDTH (SLOT_W),
    .DEPTH (TABLE_DEPTH)
  ) u_slots (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (SLOT_W'(ram_wslot)),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  pct_div u_div (
    .clk (clk),
    .rst (rst),
    .req (div_req),
    .rsp (div_rsp)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      max_candidates     <= pct_pkg::MC_W'(15);
      max_strength       <= pct_pkg::MS_W'(32767);
      unvoiced_criterion <= pct_pkg::MS_W'(14746);
    end else if (cfg_write) begin
      unique case (cfg_index)
        pct_pkg::REG_MAX_CAND: max_candidates     <= cfg_data[pct_pkg::MC_W-1:0];
        pct_pkg::REG_MAX_STR:  max_strength       <= cfg_data;
        pct_pkg::REG_UNV_CRIT: unvoiced_criterion <= cfg_data;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      count     <= '0;
      out_valid <= 1'b0;
      pend      <= 1'b0;
    end else begin
      if (state == ST_REPORT && (!out_valid || !result_stall)) begin
        out_valid <= 1'b1;
      end else if (out_valid && !result_stall) begin
        out_valid <= 1'b0;
      end
      unique case (state)
        ST_IDLE: begin
          if (cand_valid) begin
            act_r     <= cand.action;
            f_r       <= cand.cand_freq_in;
            s_r       <= cand.cand_strength_in;
            stored    <= 1'b0;
            case (cand.action)
              pct_pkg::ACT_CLEAR: begin
                count     <= '0;
                scan_kind <= SC_BEST;
                state     <= ST_SINIT;
              end
              pct_pkg::ACT_ADD: begin
                scan_kind <= SC_BEST;
                state     <= ST_ADD;
              end
              pct_pkg::ACT_NORM: begin
                scan_kind <= (count != '0) ? SC_STRONG : SC_BEST;
                state     <= ST_SINIT;
              end
              default: begin
                scan_kind <= SC_BEST;
                state     <= ST_SINIT;
              end
            endcase
          end
        end
        ST_ADD: begin
          state <= ST_SINIT;
          if (cnt_ext < lim) begin
            count     <= count + CNT_W'(1);
            stored    <= 1'b1;
            scan_kind <= SC_BEST;
          end else begin
            scan_kind <= SC_WEAK;
          end
        end
        ST_SINIT: begin
          idx      <= '0;
          pend     <= 1'b0;
          found    <= 1'b0;
          ufound   <= 1'b0;
          pos      <= '0;
          upos     <= '0;
          bfreq    <= '0;
          acc      <= (scan_kind == SC_BEST) ? pct_pkg::STR_MIN : '0;
          scan_end <= (scan_kind == SC_WEAK) ? lim : cnt_ext;
          state    <= ST_SCAN;
        end
        ST_SCAN: begin
          // read issued last cycle lands now in rd, tagged by pend_idx
          if (pend) begin
            case (scan_kind)
              SC_WEAK: begin
                if (weak_hit) begin
                  acc   <= rd.strength;
                  pos   <= pend_idx;
                  found <= 1'b1;
                end
              end
              SC_STRONG: begin
                if (strong_hit) begin
                  acc   <= rd.strength;
                  pos   <= pend_idx;
                  found <= 1'b1;
                end
                if (rd.freq == '0 && !ufound) begin
                  upos   <= pend_idx;
                  ufound <= 1'b1;
                end
              end
              default: begin
                if (best_hit) begin
                  acc <= rd.strength;
                end
                // no voiced pick falls back to slot one's frequency
                if (best_hit || pend_idx == '0) begin
                  bfreq <= rd.freq;
                end
              end
            endcase
          end
          if (scan_more) begin
            pend     <= 1'b1;
            pend_idx <= idx[IDX_W-1:0];
            idx      <= idx_inc;
          end else begin
            pend <= 1'b0;
            if (!pend) begin
              state <= ST_SDONE;
            end
          end
        end
        ST_SDONE: begin
          case (scan_kind)
            SC_WEAK: begin
              if (repl_ok) begin
                stored <= 1'b1;
              end
              scan_kind <= SC_BEST;
              state     <= ST_SINIT;
            end
            SC_STRONG: begin
              idx <= '0;
              if (acc != '0) begin
                state <= ST_NRD;
              end else begin
                state <= ST_PICK;
              end
            end
            default: begin
              state <= ST_REPORT;
            end
          endcase
        end
        ST_NRD: begin
          state <= ST_NWAIT;
        end
        ST_NWAIT: begin
          keep_f <= rd.freq;
          state  <= ST_NDIV;
        end
        ST_NDIV: begin
          if (div_rsp.done) begin
            idx <= idx_inc;
            if (idx_inc == count) begin
              state <= ST_PICK;
            end else begin
              state <= ST_NRD;
            end
          end
        end
        ST_PICK: begin
          swap_pos <= pick_pos;
          if (pick_pos != '0) begin
            state <= ST_SRD0;
          end else begin
            scan_kind <= SC_BEST;
            state     <= ST_SINIT;
          end
        end
        ST_SRD0: begin
          state <= ST_SRDP;
        end
        ST_SRDP: begin
          e0    <= rd;
          state <= ST_SWA;
        end
        ST_SWA: begin
          state <= ST_SWB;
        end
        ST_SWB: begin
          scan_kind <= SC_BEST;
          state     <= ST_SINIT;
        end
        ST_REPORT: begin
          if (!out_valid || !result_stall) begin
            out_data.best_frequency  <= bfreq;
            out_data.best_strength   <= acc;
            out_data.entry_count     <= cnt_ext[pct_pkg::CNT_OUT_W-1:0];
            out_data.was_stored      <= stored;
            state                    <= ST_IDLE;
          end
        end
        default: begin
          state <= ST_IDLE;
        end
      endcase
    end
  end

  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    count <= CNT_W'(TABLE_DEPTH))
    else $error("entry count beyond table depth");

  a_div_owner: assert property (@(posedge clk) disable iff (rst)
    div_rsp.done |-> state == ST_NDIV)
    else $error("divider finished outside the normalize loop");

  a_clear_empty: assert property (@(posedge clk) disable iff (rst)
    (state == ST_REPORT && act_r == pct_pkg::ACT_CLEAR) |-> count == '0)
    else $error("table not empty after clear");

  a_stored_add: assert property (@(posedge clk) disable iff (rst)
    (state == ST_REPORT && stored) |-> act_r == pct_pkg::ACT_ADD)
    else $error("stored flag set for an item that is not an add");

endmodule
